/* src/triangle_cell_scanner_top_macros.svh */
// assertion macros for the triangle cell scanner
// expect clk and rst_n in the scope of use
`ifndef TRIANGLE_CELL_SCANNER_TOP_MACROS_SVH
`define TRIANGLE_CELL_SCANNER_TOP_MACROS_SVH

// same-cycle implication
`define TCS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/tcs_pkg.sv */
// shared types, codes and helpers for the triangle cell scanner
// no dependencies
`default_nettype none

package tcs_pkg;

    localparam int COORD_BITS = 8;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int CENT_W     = COORD_BITS + 3;

    typedef logic [COORD_BITS-1:0] coord_t;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef enum logic [1:0] {
        ST_CELL  = 2'd0,
        ST_DEGEN = 2'd1,
        ST_IDLE  = 2'd2
    } status_t;

    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
        coord_t cx;
        coord_t cy;
    } vtx_t;

    typedef struct packed {
        logic zero;
        logic neg;
    } orient_t;

    function automatic coord_t min3(input coord_t a, input coord_t b, input coord_t c);
        coord_t m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic coord_t max3(input coord_t a, input coord_t b, input coord_t c);
        coord_t m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

endpackage

`default_nettype wire

/* src/tcs_orient.sv */
// orientation of a triangle from the centroid-relative cross product
// depends on tcs_pkg
`default_nettype none

module tcs_orient (
    input  tcs_pkg::vtx_t    vtx,
    output tcs_pkg::orient_t orient
);
    import tcs_pkg::*;

    logic signed [CENT_W-1:0]   ux;
    logic signed [CENT_W-1:0]   uy;
    logic signed [CENT_W-1:0]   vx;
    logic signed [CENT_W-1:0]   vy;
    logic signed [2*CENT_W-1:0] p1;
    logic signed [2*CENT_W-1:0] p2;
    logic signed [2*CENT_W:0]   xprod;

    // 3a - (a + b + c) == 2a - b - c
    assign ux = $signed({2'b00, vtx.ax, 1'b0}) - $signed({3'b000, vtx.bx})
              - $signed({3'b000, vtx.cx});
    assign uy = $signed({2'b00, vtx.ay, 1'b0}) - $signed({3'b000, vtx.by})
              - $signed({3'b000, vtx.cy});
    assign vx = $signed({2'b00, vtx.bx, 1'b0}) - $signed({3'b000, vtx.ax})
              - $signed({3'b000, vtx.cx});
    assign vy = $signed({2'b00, vtx.by, 1'b0}) - $signed({3'b000, vtx.ay})
              - $signed({3'b000, vtx.cy});

    assign p1    = ux * vy;
    assign p2    = uy * vx;
    assign xprod = $signed({p1[2*CENT_W-1], p1}) - $signed({p2[2*CENT_W-1], p2});

    assign orient.zero = (xprod == '0);
    assign orient.neg  = xprod[2*CENT_W];

endmodule

`default_nettype wire

/* src/tcs_edge.sv */
// inside test of one cell against the three triangle edges
// depends on tcs_pkg
`default_nettype none

module tcs_edge (
    input  tcs_pkg::vtx_t   vtx,
    input  tcs_pkg::coord_t x,
    input  tcs_pkg::coord_t y,
    input  logic            neg,
    output logic            covered
);
    import tcs_pkg::*;

    function automatic logic edge_ok(input coord_t px, input coord_t py,
                                     input coord_t qx, input coord_t qy,
                                     input coord_t cx, input coord_t cy,
                                     input logic   n);
        logic signed [DIFF_W-1:0]   dpx;
        logic signed [DIFF_W-1:0]   dpy;
        logic signed [DIFF_W-1:0]   dqx;
        logic signed [DIFF_W-1:0]   dqy;
        logic signed [2*DIFF_W-1:0] m1;
        logic signed [2*DIFF_W-1:0] m2;
        logic signed [2*DIFF_W:0]   e;
        dpx = $signed({1'b0, px}) - $signed({1'b0, cx});
        dpy = $signed({1'b0, py}) - $signed({1'b0, cy});
        dqx = $signed({1'b0, qx}) - $signed({1'b0, cx});
        dqy = $signed({1'b0, qy}) - $signed({1'b0, cy});
        m1  = dpx * dqy;
        m2  = dpy * dqx;
        e   = $signed({m1[2*DIFF_W-1], m1}) - $signed({m2[2*DIFF_W-1], m2});
        return n ? (e[2*DIFF_W] || (e == '0)) : !e[2*DIFF_W];
    endfunction

    logic ok_ab;
    logic ok_bc;
    logic ok_ca;

    assign ok_ab   = edge_ok(vtx.ax, vtx.ay, vtx.bx, vtx.by, x, y, neg);
    assign ok_bc   = edge_ok(vtx.bx, vtx.by, vtx.cx, vtx.cy, x, y, neg);
    assign ok_ca   = edge_ok(vtx.cx, vtx.cy, vtx.ax, vtx.ay, x, y, neg);
    assign covered = ok_ab && ok_bc && ok_ca;

endmodule

`default_nettype wire

/* src/triangle_cell_scanner_top.sv */
// throughput: one item per cycle, start or step, while out_stall holds no result; each beat
// passes the input and then the result register; edge and cross-product units are the path
// the input side keeps taking beats while a result waits, unless both registers are full
// reset: async active low; scan idle, vertices, box, orientation and scan position cleared
// top level of the triangle cell scanner; depends on tcs_pkg, tcs_orient, tcs_edge
// and triangle_cell_scanner_top_macros.svh
`default_nettype none

`include "triangle_cell_scanner_top_macros.svh"

module triangle_cell_scanner_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            operation,
    input  tcs_pkg::coord_t corner_a_x,
    input  tcs_pkg::coord_t corner_a_y,
    input  tcs_pkg::coord_t corner_b_x,
    input  tcs_pkg::coord_t corner_b_y,
    input  tcs_pkg::coord_t apex_x,
    input  tcs_pkg::coord_t apex_y,
    output logic            out_valid,
    input  logic            out_stall,
    output tcs_pkg::coord_t cell_x,
    output tcs_pkg::coord_t cell_y,
    output logic            inside_res,
    output logic [1:0]      status,
    output logic            last
);
    import tcs_pkg::*;

    logic    in_vld_reg;
    logic    op_reg;
    vtx_t    vin_reg;
    vtx_t    vst_reg,    vst_next;
    logic    neg_reg,    neg_next;
    coord_t  minx_reg,   minx_next;
    coord_t  miny_reg,   miny_next;
    coord_t  maxx_reg,   maxx_next;
    coord_t  maxy_reg,   maxy_next;
    coord_t  col_reg,    col_next;
    coord_t  row_reg,    row_next;
    logic    active_reg, active_next;
    logic    out_vld_reg, out_vld_next;
    coord_t  ox_reg,     ox_next;
    coord_t  oy_reg,     oy_next;
    logic    oin_reg,    oin_next;
    status_t ost_reg,    ost_next;
    logic    olast_reg,  olast_next;

    logic    adv;
    logic    fire;
    logic    take;
    logic    is_start;
    orient_t orient;
    coord_t  nminx, nminy, nmaxx, nmaxy;
    vtx_t    sel_vtx;
    logic    sel_neg;
    coord_t  cur_x, cur_y, sel_minx, sel_maxx, sel_maxy;
    logic    covered;
    logic    end_col;
    logic    end_row;

    assign adv      = !out_vld_reg || !out_stall;
    assign fire     = in_vld_reg && adv;
    assign in_stall = in_vld_reg && !adv;
    assign take     = in_valid && !in_stall;
    assign is_start = (op_reg == OP_START);

    tcs_orient u_orient (
        .vtx    (vin_reg),
        .orient (orient)
    );

    assign nminx = min3(vin_reg.ax, vin_reg.bx, vin_reg.cx);
    assign nminy = min3(vin_reg.ay, vin_reg.by, vin_reg.cy);
    assign nmaxx = max3(vin_reg.ax, vin_reg.bx, vin_reg.cx);
    assign nmaxy = max3(vin_reg.ay, vin_reg.by, vin_reg.cy);

    assign sel_vtx  = is_start ? vin_reg    : vst_reg;
    assign sel_neg  = is_start ? orient.neg : neg_reg;
    assign sel_minx = is_start ? nminx      : minx_reg;
    assign sel_maxx = is_start ? nmaxx      : maxx_reg;
    assign sel_maxy = is_start ? nmaxy      : maxy_reg;
    assign cur_x    = is_start ? nminx      : col_reg;
    assign cur_y    = is_start ? nminy      : row_reg;

    tcs_edge u_edge (
        .vtx     (sel_vtx),
        .x       (cur_x),
        .y       (cur_y),
        .neg     (sel_neg),
        .covered (covered)
    );

    assign end_col = (cur_x >= sel_maxx);
    assign end_row = (cur_y >= sel_maxy);

    always_comb
    begin
        vst_next     = vst_reg;
        neg_next     = neg_reg;
        minx_next    = minx_reg;
        miny_next    = miny_reg;
        maxx_next    = maxx_reg;
        maxy_next    = maxy_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        active_next  = active_reg;
        out_vld_next = out_vld_reg && out_stall;
        ox_next      = ox_reg;
        oy_next      = oy_reg;
        oin_next     = oin_reg;
        ost_next     = ost_reg;
        olast_next   = olast_reg;
        if (fire)
        begin
            out_vld_next = 1'b1;
            ox_next      = '0;
            oy_next      = '0;
            oin_next     = 1'b0;
            olast_next   = 1'b1;
            if (is_start)
            begin
                vst_next = vin_reg;
            end
            if (is_start && orient.zero)
            begin
                active_next = 1'b0;
                ost_next    = ST_DEGEN;
            end
            else if (!is_start && !active_reg)
            begin
                ost_next = ST_IDLE;
            end
            else
            begin
                if (is_start)
                begin
                    neg_next  = orient.neg;
                    minx_next = nminx;
                    miny_next = nminy;
                    maxx_next = nmaxx;
                    maxy_next = nmaxy;
                end
                ox_next     = cur_x;
                oy_next     = cur_y;
                oin_next    = covered;
                ost_next    = ST_CELL;
                olast_next  = end_col && end_row;
                active_next = 1'b1;
                if (end_col)
                begin
                    if (end_row)
                    begin
                        active_next = 1'b0;
                    end
                    else
                    begin
                        col_next = sel_minx;
                        row_next = cur_y + 1'b1;
                    end
                end
                else
                begin
                    col_next = cur_x + 1'b1;
                    row_next = cur_y;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            op_reg      <= OP_START;
            vin_reg     <= '0;
            vst_reg     <= '0;
            neg_reg     <= 1'b0;
            minx_reg    <= '0;
            miny_reg    <= '0;
            maxx_reg    <= '0;
            maxy_reg    <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            active_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            ox_reg      <= '0;
            oy_reg      <= '0;
            oin_reg     <= 1'b0;
            ost_reg     <= ST_IDLE;
            olast_reg   <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                in_vld_reg <= 1'b1;
                op_reg     <= operation;
                vin_reg    <= '{ax: corner_a_x, ay: corner_a_y, bx: corner_b_x,
                                by: corner_b_y, cx: apex_x, cy: apex_y};
            end
            else if (fire)
            begin
                in_vld_reg <= 1'b0;
            end
            vst_reg     <= vst_next;
            neg_reg     <= neg_next;
            minx_reg    <= minx_next;
            miny_reg    <= miny_next;
            maxx_reg    <= maxx_next;
            maxy_reg    <= maxy_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            active_reg  <= active_next;
            out_vld_reg <= out_vld_next;
            ox_reg      <= ox_next;
            oy_reg      <= oy_next;
            oin_reg     <= oin_next;
            ost_reg     <= ost_next;
            olast_reg   <= olast_next;
        end
    end

    assign out_valid  = out_vld_reg;
    assign cell_x     = ox_reg;
    assign cell_y     = oy_reg;
    assign inside_res = oin_reg;
    assign status     = ost_reg;
    assign last       = olast_reg;

    // non-cell beats are final and carry no cell
    `TCS_ASSERT_IMP(a_noncell_beat, (out_vld_reg && (ost_reg != ST_CELL)),
        (olast_reg && (ox_reg == '0) && (oy_reg == '0) && !oin_reg),
        "degenerate or idle beat with cell data or without last")
    // a reported cell lies in the current box
    `TCS_ASSERT_IMP(a_cell_in_box, (out_vld_reg && (ost_reg == ST_CELL)),
        ((ox_reg >= minx_reg) && (ox_reg <= maxx_reg) && (oy_reg >= miny_reg)
            && (oy_reg <= maxy_reg)),
        "reported cell outside the bounding box")
    // the final cell of a box ends the scan
    `TCS_ASSERT_NXT(a_last_ends_scan, (fire && (ost_next == ST_CELL) && olast_next),
        !active_reg, "scan still active after its last cell")

endmodule

`default_nettype wire
